// File: rtl/core/plist_pkg.sv
`timescale 1ns / 1ps

package plist_pkg;

    // Default list depth
    localparam int DEFAULT_CAPACITY = 128;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 7;
    localparam int COUNT_W  = 8;

    // Match bits examined per search cycle (power of two)
    localparam int SCAN_W = 32;

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PEND
    } state_t;

    // Shift command broadcast to every entry cell
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] value;
    } cell_ctl_t;

    // Search scan status toward the controller
    typedef struct packed {
        logic               hit;
        logic               last;
        logic [FOUND_W-1:0] pos;
    } scan_stat_t;

endpackage

// File: rtl/core/plist_cell.sv
`timescale 1ns / 1ps

module plist_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 8
) (
    input  logic                                aclk,
    input  plist_pkg::cell_ctl_t                ctl,
    input  logic [CNT_W-1:0]                    count,
    input  logic signed [plist_pkg::VALUE_W-1:0] left_data,
    input  logic signed [plist_pkg::VALUE_W-1:0] right_data,
    output logic signed [plist_pkg::VALUE_W-1:0] data,
    output logic                                eq
);
    import plist_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] IDX = CMP_W'(CELL_IDX);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          cnt_ext;

    assign pos_ext = CMP_W'(ctl.pos);
    assign cnt_ext = CMP_W'(count);

    // On insert value at pos, left data above; right data on delete
    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins) begin
            if (IDX > pos_ext) begin
                entry_next = left_data;
            end else if (IDX == pos_ext) begin
                entry_next = ctl.value;
            end
        end else if (ctl.del && (IDX >= pos_ext)) begin
            entry_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    // Compare only live entries
    assign eq   = (entry_reg == ctl.value) && (IDX < cnt_ext);
    assign data = entry_reg;

endmodule

// File: rtl/core/plist_scan.sv
`timescale 1ns / 1ps

module plist_scan #(
    parameter int CAPACITY = plist_pkg::DEFAULT_CAPACITY
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  logic                  step,
    input  logic [CAPACITY-1:0]   eq_vec,
    output plist_pkg::scan_stat_t stat
);
    import plist_pkg::*;

    localparam int NCHUNK  = (CAPACITY + SCAN_W - 1) / SCAN_W;
    localparam int VEC_W   = NCHUNK * SCAN_W;
    localparam int CH_W    = $clog2(NCHUNK + 1);
    localparam int SCAN_SH = $clog2(SCAN_W);
    localparam int PW      = CH_W + SCAN_SH + FOUND_W;

    logic [VEC_W-1:0]   match_reg;
    logic [VEC_W-1:0]   match_next;
    logic [CH_W-1:0]    chunk_reg;
    logic [CH_W-1:0]    chunk_next;
    logic [SCAN_W-1:0]  low;
    logic [SCAN_SH-1:0] enc;
    logic [PW-1:0]      pos_full;

    // Capture match flags, then drop one chunk per cycle while step is high
    always_comb begin
        match_next = match_reg;
        chunk_next = chunk_reg;
        if (load) begin
            match_next = VEC_W'(eq_vec);
            chunk_next = '0;
        end else if (step) begin
            match_next = match_reg >> SCAN_W;
            chunk_next = chunk_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        match_reg <= match_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg <= '0;
        end else begin
            chunk_reg <= chunk_next;
        end
    end

    // Find the lowest set flag of the current chunk
    assign low = match_reg[SCAN_W-1:0];

    always_comb begin
        enc = '0;
        for (int k = SCAN_W - 1; k >= 0; k--) begin
            if (low[k]) begin
                enc = SCAN_SH'(k);
            end
        end
    end

    assign pos_full  = PW'({chunk_reg, enc});
    assign stat.hit  = |low;
    assign stat.last = (chunk_reg == CH_W'(NCHUNK - 1));
    assign stat.pos  = pos_full[FOUND_W-1:0];

endmodule

// File: rtl/core/positional_list_insert_delete_search_top.sv
`timescale 1ns / 1ps
// Channel | Ports                                     | Transfer when
// --------+-------------------------------------------+---------------------
// request | s_func, s_value, s_position               | s_valid & s_ready
// result  | m_status, m_found_position, m_entry_count | m_valid & m_ready
//
// Insert, delete, unused codes and a search of an empty list finish without a scan;
// the next request can follow in the next cycle if the output register is free.
// A search runs the match scan, which examines 32 entry cells per cycle and
// stops at the first hit or at the last chunk.
// Reset clears the count and control; entry cells are not cleared.
// One result waits in the output register while the next request is taken;
// a second finished result holds in the pending stage with s_ready low.

module positional_list_insert_delete_search_top #(
    parameter int CAPACITY = plist_pkg::DEFAULT_CAPACITY
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [plist_pkg::FUNC_W-1:0]         s_func,
    input  logic signed [plist_pkg::VALUE_W-1:0] s_value,
    input  logic [plist_pkg::POS_W-1:0]          s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [plist_pkg::STATUS_W-1:0]       m_status,
    output logic [plist_pkg::FOUND_W-1:0]        m_found_position,
    output logic [plist_pkg::COUNT_W-1:0]        m_entry_count
);
    import plist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_after;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] after_ext;

    logic acc;
    logic is_full;
    logic is_empty;
    logic do_ins;
    logic do_del;
    logic go_scan;
    logic [STATUS_W-1:0] imm_status;

    logic                fin_valid;
    logic [STATUS_W-1:0] fin_status;
    logic [FOUND_W-1:0]  fin_found;
    logic [COUNT_W-1:0]  fin_count;
    logic                out_free;
    logic                out_load;

    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic [FOUND_W-1:0]  res_found_reg;
    logic [FOUND_W-1:0]  res_found_next;
    logic [COUNT_W-1:0]  res_count_reg;
    logic [COUNT_W-1:0]  res_count_next;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [FOUND_W-1:0]  m_found_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    cell_ctl_t  ctl;
    scan_stat_t stat;
    logic       scan_load;
    logic       scan_step;

    logic signed [VALUE_W-1:0] cell_data  [CAPACITY];
    logic signed [VALUE_W-1:0] left_bus   [CAPACITY];
    logic signed [VALUE_W-1:0] right_bus  [CAPACITY];
    logic [CAPACITY-1:0]       eq_vec;

    assign acc      = s_valid && s_ready;
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_ext  = CMP_W'(s_position);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Decode the request against the current count
    always_comb begin
        imm_status = STAT_OK;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        go_scan    = 1'b0;
        case (s_func)
            OP_INSERT: begin
                if (is_full) begin
                    imm_status = STAT_FULL;
                end else if (pos_ext > cnt_ext) begin
                    imm_status = STAT_BADPOS;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_DELETE: begin
                if (is_empty) begin
                    imm_status = STAT_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    imm_status = STAT_BADPOS;
                end else begin
                    do_del = 1'b1;
                end
            end
            OP_SEARCH: begin
                if (is_empty) begin
                    imm_status = STAT_EMPTY;
                end else begin
                    go_scan = 1'b1;
                end
            end
            default: begin
                imm_status = STAT_OK;
            end
        endcase
    end

    always_comb begin
        count_after = count_reg;
        if (do_ins) begin
            count_after = count_reg + 1'b1;
        end else if (do_del) begin
            count_after = count_reg - 1'b1;
        end
    end

    assign after_ext  = CMP_W'(count_after);
    assign count_next = acc ? count_after : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Broadcast the shift command to the cell row
    assign ctl.ins   = acc && do_ins;
    assign ctl.del   = acc && do_del;
    assign ctl.pos   = s_position;
    assign ctl.value = s_value;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign left_bus[gi] = s_value;
        end else begin : g_mid_l
            assign left_bus[gi] = cell_data[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign right_bus[gi] = cell_data[gi];
        end else begin : g_mid_r
            assign right_bus[gi] = cell_data[gi+1];
        end

        plist_cell #(
            .CELL_IDX (gi),
            .CNT_W    (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .count      (count_reg),
            .left_data  (left_bus[gi]),
            .right_data (right_bus[gi]),
            .data       (cell_data[gi]),
            .eq         (eq_vec[gi])
        );
    end

    assign scan_load = acc && go_scan;
    assign scan_step = (state_reg == S_SCAN) && !(stat.hit || stat.last);

    plist_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (scan_load),
        .step    (scan_step),
        .eq_vec  (eq_vec),
        .stat    (stat)
    );

    // Select the finished result of this cycle
    always_comb begin
        fin_valid  = 1'b0;
        fin_status = STAT_OK;
        fin_found  = '0;
        fin_count  = after_ext[COUNT_W-1:0];
        case (state_reg)
            S_IDLE: begin
                fin_valid  = acc && !go_scan;
                fin_status = imm_status;
            end
            S_SCAN: begin
                fin_valid  = stat.hit || stat.last;
                fin_status = stat.hit ? STAT_OK : STAT_NOTFOUND;
                fin_found  = stat.hit ? stat.pos : '0;
                fin_count  = res_count_reg;
            end
            S_PEND: begin
                fin_valid  = 1'b1;
                fin_status = res_status_reg;
                fin_found  = res_found_reg;
                fin_count  = res_count_reg;
            end
            default: begin
                fin_valid = 1'b0;
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = fin_valid && out_free;

    // Hold a finished result while the output register is busy; latch the count on each accepted request
    always_comb begin
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_count_next  = res_count_reg;
        if (acc) begin
            res_count_next = after_ext[COUNT_W-1:0];
        end
        if (fin_valid && !out_free) begin
            res_status_next = fin_status;
            res_found_next  = fin_found;
            res_count_next  = fin_count;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_count_reg  <= res_count_next;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    if (go_scan) begin
                        state_next = S_SCAN;
                    end else if (!out_free) begin
                        state_next = S_PEND;
                    end
                end
            end
            S_SCAN: begin
                if (fin_valid) begin
                    state_next = out_free ? S_IDLE : S_PEND;
                end
            end
            S_PEND: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        case (state_reg)
            S_IDLE:  s_ready = 1'b1;
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= fin_status;
            m_found_reg  <= fin_found;
            m_count_reg  <= fin_count;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_found_reg;
    assign m_entry_count    = m_count_reg;

endmodule

// File: rtl/core/plist_checker.sv
`timescale 1ns / 1ps

module plist_checker #(
    parameter int CAPACITY = plist_pkg::DEFAULT_CAPACITY
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [plist_pkg::STATUS_W-1:0]       m_status,
    input logic [plist_pkg::FOUND_W-1:0]        m_found_position,
    input logic [plist_pkg::COUNT_W-1:0]        m_entry_count
);
    import plist_pkg::*;

    localparam logic [COUNT_W-1:0] CAP8 = COUNT_W'(CAPACITY);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_found_position) && $stable(m_entry_count))
        else $error("result changed while stalled");

    // Full is reported only at capacity
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_FULL) |-> m_entry_count == CAP8)
        else $error("full status with count below capacity");

    // Empty is reported only with no entries
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_EMPTY) |-> m_entry_count == '0)
        else $error("empty status with entries present");

    // Position is zero whenever the status is not OK
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |-> m_found_position == '0)
        else $error("found position set on a failed request");

endmodule

bind positional_list_insert_delete_search_top plist_checker #(
    .CAPACITY (CAPACITY)
) u_plist_checker (.*);
